FILE: rtl/sync_word_length_deframer_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; included by the modules that check their own logic
`ifndef SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define SWLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swld same-cycle check failed");

// next-cycle implication, checked outside reset
`define SWLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swld next-cycle check failed");

`else

`define SWLD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SWLD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/swld_pkg.sv
// shared types and constants of the sync word / length deframer
// no dependencies
package swld_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int SYNC_WIDTH      = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_WORD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_COPY  = 2'd1;

   localparam logic [SYNC_WIDTH-1:0] SYNC_WORD_RESET = 24'hFAF320;
   localparam logic [BYTE_WIDTH-1:0] MAX_COPY_RESET  = 8'd255;

   // frame phase codes
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   typedef struct packed {
      logic                  valid;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  frame_last;
      logic                  truncated;
   } result_type;

endpackage

FILE: rtl/swld_hunt.sv
// sliding two-byte window and sync word compare
// depends on swld_pkg
module swld_hunt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [swld_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  logic [swld_pkg::SYNC_WIDTH-1:0] sync_word,
   output logic                           match
);
   import swld_pkg::*;

   logic [2*BYTE_WIDTH-1:0] window_ff, window_in;
   logic [1:0]              fill_ff, fill_in;

   assign match = (fill_ff == 2'd2) && ({window_ff, rx_byte} == sync_word);

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (step) begin
         if (match) begin
            window_in = '0;
            fill_in   = 2'd0;
         end else begin
            window_in = {window_ff[BYTE_WIDTH-1:0], rx_byte};
            fill_in   = (fill_ff == 2'd2) ? 2'd2 : fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= 2'd0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: rtl/swld_frame.sv
// frame phase tracking, length capture and payload delivery
// depends on swld_pkg
module swld_frame (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [swld_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  logic [swld_pkg::BYTE_WIDTH-1:0] max_copy,
   input  logic                            match,
   output logic                            hunting,
   output swld_pkg::result_type            result
);
   import swld_pkg::*;

   logic [1:0]            phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0] remain_ff, remain_in;
   logic [BYTE_WIDTH-1:0] deliver_ff, deliver_in;
   logic                  cut_ff, cut_in;
   logic [BYTE_WIDTH-1:0] remain_dec;
   logic                  too_long;

   // the unused phase code behaves as hunting
   assign hunting    = (phase_ff != PH_LEN) && (phase_ff != PH_DATA);
   assign remain_dec = remain_ff - 8'd1;
   assign too_long   = rx_byte > max_copy;

   always_comb begin
      phase_in          = phase_ff;
      remain_in         = remain_ff;
      deliver_in        = deliver_ff;
      cut_in            = cut_ff;
      result.valid      = 1'b0;
      result.data_byte  = rx_byte;
      result.frame_last = 1'b0;
      result.truncated  = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (rx_byte == '0) begin
                  phase_in = PH_HUNT;
               end else begin
                  remain_in  = rx_byte;
                  deliver_in = too_long ? max_copy : rx_byte;
                  cut_in     = too_long;
                  phase_in   = PH_DATA;
               end
            end
            PH_DATA: begin
               remain_in = remain_dec;
               if (deliver_ff != '0) begin
                  deliver_in        = deliver_ff - 8'd1;
                  result.valid      = 1'b1;
                  result.frame_last = (deliver_ff == 8'd1);
                  result.truncated  = (deliver_ff == 8'd1) && cut_ff;
               end
               if (remain_dec == '0) begin
                  phase_in   = PH_HUNT;
                  deliver_in = '0;
                  cut_in     = 1'b0;
               end
            end
            default: begin
               phase_in = match ? PH_LEN : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         remain_ff  <= '0;
         deliver_ff <= '0;
         cut_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         remain_ff  <= remain_in;
         deliver_ff <= deliver_in;
         cut_ff     <= cut_in;
      end
   end

endmodule

FILE: rtl/sync_word_length_deframer.sv
// sync word / length prefixed frame deframer, top level
// depends on swld_pkg, swld_hunt, swld_frame and the assertion macro header
//
// Byte-wide deframer: each item is one received byte. While hunting, the block
// slides a two-byte window over the stream and looks for the 24-bit sync word
// (first byte on the link in bits 23..16). The byte after a match is the
// payload length L; a zero length frame is skipped. Of the next L bytes, the
// first min(L, max_copy) come out on the rsp channel, the rest are consumed
// silently. The last delivered byte carries frame_last, plus truncated when
// bytes were dropped. Sync, length and dropped bytes give no result. The block
// takes one item per cycle while rsp is not stalled: an item is registered on
// accept and processed, once the result register is free, by the hunt compare
// and the frame counters, which write the result register. A stalled rsp side
// holds the result register and backs up through the input register. Write the
// csr registers only while the block is idle; max_copy is sampled when the
// length byte is processed. No clearing pass after reset.
`include "sync_word_length_deframer_macros.svh"

module sync_word_length_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   // input bytes
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [swld_pkg::BYTE_WIDTH-1:0]      req_rx_byte,
   // delivered payload bytes
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [swld_pkg::BYTE_WIDTH-1:0]      rsp_data_byte,
   output logic                                 rsp_frame_last,
   output logic                                 rsp_truncated,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swld_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [swld_pkg::SYNC_WIDTH-1:0]      csr_wdata
);
   import swld_pkg::*;

   // configuration registers
   logic [SYNC_WIDTH-1:0] sync_word_ff, sync_word_in;
   logic [BYTE_WIDTH-1:0] max_copy_ff, max_copy_in;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff, in_byte_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic       advance;     // the registered item is processed this cycle
   logic       hunt_step;
   logic       match;
   logic       hunting;
   result_type result;

   // always able to take a register write
   assign csr_ready = 1'b1;

   always_comb begin
      sync_word_in = sync_word_ff;
      max_copy_in  = max_copy_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_WORD: sync_word_in = csr_wdata;
            CSR_MAX_COPY:  max_copy_in  = csr_wdata[BYTE_WIDTH-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // process the held item once the result register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign hunt_step = advance && hunting;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   swld_hunt u_hunt (
      .clock     (clock),
      .reset     (reset),
      .step      (hunt_step),
      .rx_byte   (in_byte_ff),
      .sync_word (sync_word_ff),
      .match     (match)
   );

   swld_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .rx_byte  (in_byte_ff),
      .max_copy (max_copy_ff),
      .match    (match),
      .hunting  (hunting),
      .result   (result)
   );

   // result register: loaded on advance, emptied when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= SYNC_WORD_RESET;
         max_copy_ff  <= MAX_COPY_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sync_word_ff <= sync_word_in;
         max_copy_ff  <= max_copy_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_ff.data_byte;
   assign rsp_frame_last = rsp_ff.frame_last;
   assign rsp_truncated  = rsp_ff.truncated;

   // a pending result is never overwritten by the next item
   `SWLD_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !advance)
   // an accepted item lands in the input register
   `SWLD_ASSERT_NXT(a_accept_loads, clock, reset, req_valid && req_ready, in_valid_ff)
   // truncation is only flagged on the last byte of a frame
   `SWLD_ASSERT_IMP(a_trunc_last, clock, reset, rsp_valid && rsp_truncated, rsp_frame_last)
   // a taken result with nothing behind it leaves the output empty
   `SWLD_ASSERT_NXT(a_drain, clock, reset, rsp_valid_ff && rsp_ready && !advance,
                    !rsp_valid_ff)

endmodule
